@@ rtl/core/query_string_pair_decoder_core_macros.svh @@
// Assertion macros used by the query string decoder checker.
`ifndef QUERY_STRING_PAIR_DECODER_CORE_MACROS_SVH
`define QUERY_STRING_PAIR_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define QSPD_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("query string decoder check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define QSPD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("query string decoder check failed");

`endif

@@ rtl/core/qspd_pkg.sv @@
// Types, character codes and helper functions of the query string decoder.
package qspd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam int unsigned MAX_TOKENS = 4;
    localparam int unsigned COUNT_W    = $clog2(MAX_TOKENS + 1);
    localparam int unsigned SLOT_W     = $clog2(MAX_TOKENS);

    typedef enum logic [1:0] {
        TK_KEY       = 2'd0,
        TK_VALUE     = 2'd1,
        TK_END_VALUE = 2'd2,
        TK_END_KEY   = 2'd3
    } token_kind_t;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_state_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  data;
    } token_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         count;
        logic                       last;
        token_t [MAX_TOKENS-1:0]    tok;
    } bundle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_decode(logic [7:0] c);
        hex_t h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            h.valid = 1'b1;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            h.valid = 1'b1;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            h.valid = 1'b1;
        end
        h.nibble = d[3:0];
        return h;
    endfunction

    function automatic bundle_t push_token(bundle_t b, token_kind_t k, logic [7:0] v);
        bundle_t r;
        r = b;
        if (r.count < COUNT_W'(MAX_TOKENS))
        begin
            r.tok[r.count[SLOT_W-1:0]] = '{kind: k, data: v};
            r.count = r.count + COUNT_W'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/query_string_pair_decoder_core.sv @@
// Path: bundle queue, then the back end's bundle register, then its output register.
// Throughput: one byte beat per cycle while the bundle queue has room; a byte makes zero to four
// result beats; the back end delivers one result beat per cycle while m_tready is high.
// The QUEUE_DEPTH entry bundle queue absorbs bursts between the front and back ends.
// Reset: rst_n low asynchronously clears decoder state, queue pointers and output valid.
module query_string_pair_decoder_core
    import qspd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] token_kind
    output logic       m_tlast
);

    logic    q_full;
    logic    push_valid;
    bundle_t push_bundle;
    logic    pop;
    logic    head_valid;
    bundle_t head_bundle;
    token_t  tok;

    qspd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_bundle (push_bundle)
    );

    qspd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push_valid),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_bundle (head_bundle)
    );

    qspd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_bundle (head_bundle),
        .pop         (pop),
        .tok_valid   (m_tvalid),
        .tok_ready   (m_tready),
        .tok         (tok),
        .tok_last    (m_tlast)
    );

    assign m_tdata = tok.data;
    assign m_tuser = tok.kind;

endmodule

@@ rtl/core/qspd_front.sv @@
// Front end: accepts raw bytes, tracks escape and pair state, builds token bundles.
module qspd_front
    import qspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push_valid,
    output bundle_t    push_bundle
);

    logic       vm_reg, vm_next;
    esc_state_t esc_reg, esc_next;
    logic [3:0] hn_reg, hn_next;
    logic [7:0] fdc_reg, fdc_next;
    logic       kn_reg, kn_next;

    bundle_t     b;
    token_kind_t dk;
    hex_t        hx;
    logic        reproc;
    logic        accept;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && (b.count != '0);
    assign push_bundle = b;

    always_comb
    begin
        b        = '0;
        b.last   = in_last;
        vm_next  = vm_reg;
        esc_next = esc_reg;
        hn_next  = hn_reg;
        fdc_next = fdc_reg;
        kn_next  = kn_reg;
        dk       = vm_reg ? TK_VALUE : TK_KEY;
        hx       = hex_decode(in_byte);
        reproc   = 1'b0;

        if (in_byte == CHAR_AMP || in_byte == CHAR_EQUAL)
        begin
            if (esc_reg == ESC_PCT)
            begin
                b = push_token(b, dk, CHAR_PERCENT);
            end
            else if (esc_reg == ESC_DIGIT)
            begin
                b = push_token(b, dk, CHAR_PERCENT);
                b = push_token(b, dk, fdc_reg);
            end
            esc_next = ESC_NONE;
            if (in_byte == CHAR_EQUAL && !vm_reg)
            begin
                vm_next = 1'b1;
            end
            else
            begin
                if (vm_reg)
                begin
                    b = push_token(b, TK_END_VALUE, 8'h00);
                end
                else if (kn_reg)
                begin
                    b = push_token(b, TK_END_KEY, 8'h00);
                end
                vm_next = 1'b0;
                kn_next = 1'b0;
            end
            if (in_last && vm_next)
            begin
                b = push_token(b, TK_END_VALUE, 8'h00);
            end
        end
        else
        begin
            if (!vm_reg)
            begin
                kn_next = 1'b1;
            end
            unique case (esc_reg)
                ESC_PCT:
                begin
                    if (hx.valid)
                    begin
                        hn_next  = hx.nibble;
                        fdc_next = in_byte;
                        esc_next = ESC_DIGIT;
                    end
                    else
                    begin
                        b = push_token(b, dk, CHAR_PERCENT);
                        reproc = 1'b1;
                    end
                end
                ESC_DIGIT:
                begin
                    if (hx.valid)
                    begin
                        b = push_token(b, dk, {hn_reg, hx.nibble});
                        esc_next = ESC_NONE;
                    end
                    else
                    begin
                        b = push_token(b, dk, CHAR_PERCENT);
                        b = push_token(b, dk, fdc_reg);
                        reproc = 1'b1;
                    end
                end
                default:
                begin
                    reproc = 1'b1;
                end
            endcase
            if (reproc)
            begin
                esc_next = ESC_NONE;
                if (in_byte == CHAR_PLUS)
                begin
                    b = push_token(b, dk, CHAR_SPACE);
                end
                else if (in_byte == CHAR_PERCENT)
                begin
                    esc_next = ESC_PCT;
                end
                else
                begin
                    b = push_token(b, dk, in_byte);
                end
            end
            if (in_last)
            begin
                if (esc_next == ESC_PCT)
                begin
                    b = push_token(b, dk, CHAR_PERCENT);
                end
                else if (esc_next == ESC_DIGIT)
                begin
                    b = push_token(b, dk, CHAR_PERCENT);
                    b = push_token(b, dk, fdc_next);
                end
                if (vm_reg)
                begin
                    b = push_token(b, TK_END_VALUE, 8'h00);
                end
                else if (kn_next)
                begin
                    b = push_token(b, TK_END_KEY, 8'h00);
                end
            end
        end

        if (in_last)
        begin
            vm_next  = 1'b0;
            esc_next = ESC_NONE;
            hn_next  = '0;
            fdc_next = '0;
            kn_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg  <= 1'b0;
            esc_reg <= ESC_NONE;
            hn_reg  <= '0;
            fdc_reg <= '0;
            kn_reg  <= 1'b0;
        end
        else if (accept)
        begin
            vm_reg  <= vm_next;
            esc_reg <= esc_next;
            hn_reg  <= hn_next;
            fdc_reg <= fdc_next;
            kn_reg  <= kn_next;
        end
    end

endmodule

@@ rtl/core/qspd_queue.sv @@
// Short queue of token bundles between the front end and the back end.
module qspd_queue
    import qspd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head_bundle
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full        = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid  = (cnt_reg != '0);
    assign head_bundle = mem[rd_ptr_reg];
    assign do_push     = push && !full;
    assign do_pop      = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/qspd_back.sv @@
// Back end: unpacks token bundles and delivers one token beat per cycle while tok_ready is high.
module qspd_back
    import qspd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  bundle_t head_bundle,
    output logic    pop,
    output logic    tok_valid,
    input  logic    tok_ready,
    output token_t  tok,
    output logic    tok_last
);

    bundle_t             cur_reg;
    logic                cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    token_t              out_tok_reg;
    logic                out_last_reg;
    logic                adv;
    logic                cur_done;
    logic                issue;

    assign adv      = !out_valid_reg || tok_ready;
    assign cur_done = ({1'b0, idx_reg} + COUNT_W'(1)) == cur_reg.count;
    assign issue    = adv && cur_valid_reg;
    assign pop      = head_valid && (!cur_valid_reg || (issue && cur_done));

    assign tok_valid = out_valid_reg;
    assign tok       = out_tok_reg;
    assign tok_last  = out_last_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            if (cur_done)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + SLOT_W'(1);
            end
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_tok_reg  <= cur_reg.tok[idx_reg];
            out_last_reg <= cur_reg.last && cur_done;
        end
        if (pop)
        begin
            cur_reg <= head_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/qspd_checker.sv @@
// Port-level checker for the query string decoder and its bind statement.
`include "query_string_pair_decoder_core_macros.svh"

module qspd_checker
    import qspd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    logic        prev_value_reg, prev_value_next;
    logic [8:0]  in_word;
    logic [10:0] out_word;
    logic        out_is_end;
    logic        out_value_side;

    assign in_word        = {s_tdata, s_tlast};
    assign out_word       = {m_tdata, m_tuser, m_tlast};
    assign out_is_end     = (m_tuser == TK_END_VALUE) || (m_tuser == TK_END_KEY);
    assign out_value_side = (m_tuser == TK_VALUE) || (m_tuser == TK_END_VALUE);

    always_comb
    begin
        prev_value_next = prev_value_reg;
        if (m_tvalid && m_tready)
        begin
            prev_value_next = (m_tuser == TK_VALUE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_value_reg <= 1'b0;
        end
        else
        begin
            prev_value_reg <= prev_value_next;
        end
    end

    // A stalled input beat holds its contents.
    `QSPD_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(in_word))

    // A stalled result beat holds its contents.
    `QSPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

    // Pair end tokens carry a zero byte.
    `QSPD_ASSERT_IMPLIES(a_end_zero, m_tvalid && out_is_end, m_tdata == 8'h00)

    // The final beat of a string is always a pair end token.
    `QSPD_ASSERT_IMPLIES(a_last_is_end, m_tvalid && m_tlast, out_is_end)

    // A value byte is followed only by another value byte or the end of its pair.
    `QSPD_ASSERT_IMPLIES(a_value_order, m_tvalid && prev_value_reg, out_value_side)

endmodule

bind query_string_pair_decoder_core qspd_checker u_qspd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
